### design/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared widths, operation codes, cell control type and a mask helper for the
// toroidal life grid engine.
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int ROW_W  = 64;
  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [SIZE_W-1:0] MIN_SIZE = 7'd3;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [ROW_W-1:0] size_mask(input logic [SIZE_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (SIZE_W'(j) < n);
    end
    return m;
  endfunction

endpackage

### design/tlg_cell.sv
// ----------------------------------------------------------------------------
// tlg_cell
// One row of the grid. Clears on clear; otherwise takes its neighbor's row
// on a shift, or the inserted row when it is the tail of the active ring.
// ----------------------------------------------------------------------------
module tlg_cell import tlg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             tail_i,
  input  logic [ROW_W-1:0] nbr_i,
  input  logic [ROW_W-1:0] ins_i,
  output logic [ROW_W-1:0] row_o
);

  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.clear) begin
      row_d = '0;
    end else if (ctrl_i.shift) begin
      row_d = tail_i ? ins_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

### design/tlg_rule.sv
// ----------------------------------------------------------------------------
// tlg_rule
// B3/S23 next row from three consecutive rows, columns wrapping at the
// active grid size.
// ----------------------------------------------------------------------------
module tlg_rule import tlg_pkg::*; (
  input  logic [ROW_W-1:0]  up_i,
  input  logic [ROW_W-1:0]  mid_i,
  input  logic [ROW_W-1:0]  dn_i,
  input  logic [SIZE_W-1:0] size_i,
  output logic [ROW_W-1:0]  next_o
);

  logic [IDX_W-1:0] lsel;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;

  assign lsel = IDX_W'(size_i - 7'd1);
  assign mask = size_mask(size_i);

  // left neighbor of column 0 is the last active column, right of it is column 0
  always_comb begin
    up_l  = {up_i[ROW_W-2:0],  up_i[lsel]};
    mid_l = {mid_i[ROW_W-2:0], mid_i[lsel]};
    dn_l  = {dn_i[ROW_W-2:0],  dn_i[lsel]};
    up_r  = {up_i[0],  up_i[ROW_W-1:1]};
    mid_r = {mid_i[0], mid_i[ROW_W-1:1]};
    dn_r  = {dn_i[0],  dn_i[ROW_W-1:1]};
    up_r[lsel]  = up_i[0];
    mid_r[lsel] = mid_i[0];
    dn_r[lsel]  = dn_i[0];
  end

  always_comb begin
    logic [3:0] cnt;
    next_o = '0;
    for (int j = 0; j < ROW_W; j++) begin
      cnt = 4'(up_l[j]) + 4'(up_i[j]) + 4'(up_r[j]) + 4'(mid_l[j]) + 4'(mid_r[j])
          + 4'(dn_l[j]) + 4'(dn_i[j]) + 4'(dn_r[j]);
      next_o[j] = ((cnt == 4'd3) || (mid_i[j] && (cnt == 4'd2))) && mask[j];
    end
  end

endmodule

### design/toroidal_life_grid_engine.sv
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// Toroidal B3/S23 life grid held in a ring of row cells. In-range toggle and
// read, and step, rotate the active rows through the head cell, one row a cycle.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, func, row, col     | upstream -> block
//   out     | out_valid_o/out_ready_i, row_cells,status | block -> downstream
//   cfg     | cfg_we_i, cfg_wdata_i (grid_size)         | write only
//
// clear and out-of-range items go straight to the output stage without
// rotating the ring, which moves one row past the head cell and the rule unit
// per cycle.
// reset clears the grid and sets grid_size to min(MAX_SIZE, 64).
// a result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine import tlg_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [IDX_W-1:0]  col_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ROW_W-1:0]  row_cells_o,
  output logic              status_o
);

  localparam int CAP = (MAX_SIZE < 64) ? MAX_SIZE : 64;
  localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]  hrow_q, hrow_d;
  logic [IDX_W-1:0]  prow_q, prow_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] last_q, last_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [IDX_W-1:0]  op_row_q, op_row_d;
  logic [IDX_W-1:0]  op_col_q, op_col_d;
  logic [ROW_W-1:0]  res_row_q, res_row_d;
  logic              res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic              out_stat_q, out_stat_d;
  logic [ROW_W-1:0]  win1_q, win1_d;
  logic [ROW_W-1:0]  win2_q, win2_d;

  cell_ctrl_t        cell_ctrl;
  logic [ROW_W-1:0]  ins_row;
  logic [ROW_W-1:0]  rule_row;
  logic [ROW_W-1:0]  head_row;
  logic [ROW_W-1:0]  cell_row [CAP];
  logic [CAP-1:0]    tail;
  logic              row_ok, col_ok;
  logic [IDX_W-1:0]  hrow_nx, base_nx;
  logic [SIZE_W-1:0] sat_size;

  // row ring
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [ROW_W-1:0] nbr;
    if (i < CAP - 1) begin : g_mid
      assign nbr = cell_row[i+1];
    end else begin : g_end
      assign nbr = ins_row;
    end
    assign tail[i] = (size_q == SIZE_W'(i + 1));
    tlg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .tail_i (tail[i]),
      .nbr_i  (nbr),
      .ins_i  (ins_row),
      .row_o  (cell_row[i])
    );
  end

  assign head_row = cell_row[0];

  tlg_rule u_rule (
    .up_i   (win2_q),
    .mid_i  (win1_q),
    .dn_i   (head_row),
    .size_i (size_q),
    .next_o (rule_row)
  );

  assign hrow_nx = (({1'b0, hrow_q} + 7'd1) == size_q) ? '0 : hrow_q + 6'd1;
  assign base_nx = (({1'b0, base_q} + 7'd1) == size_q) ? '0 : base_q + 6'd1;
  assign row_ok  = ({1'b0, row_index_i} < size_q);
  assign col_ok  = ({1'b0, col_index_i} < size_q);

  always_comb begin
    if (cfg_wdata_i < MIN_SIZE) begin
      sat_size = MIN_SIZE;
    end else if (cfg_wdata_i > CAP_SIZE) begin
      sat_size = CAP_SIZE;
    end else begin
      sat_size = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    base_d      = base_q;
    hrow_d      = hrow_q;
    prow_d      = prow_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    func_d      = func_q;
    op_row_d    = op_row_q;
    op_col_d    = op_col_q;
    res_row_d   = res_row_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_stat_d  = out_stat_q;
    win1_d      = win1_q;
    win2_d      = win2_q;
    cell_ctrl   = '0;
    ins_row     = head_row;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d     = func_i;
          op_row_d   = row_index_i;
          op_col_d   = col_index_i;
          hrow_d     = base_q;
          cnt_d      = '0;
          res_row_d  = '0;
          res_stat_d = STATUS_DONE;
          case (func_i)
            FUNC_TOGGLE: begin
              if (row_ok && col_ok) begin
                last_d  = size_q - 7'd1;
                state_d = ST_RUN;
              end else begin
                res_stat_d = STATUS_RANGE;
                state_d    = ST_HOLD;
              end
            end
            FUNC_READ: begin
              if (row_ok) begin
                last_d  = size_q - 7'd1;
                state_d = ST_RUN;
              end else begin
                res_stat_d = STATUS_RANGE;
                state_d    = ST_HOLD;
              end
            end
            FUNC_STEP: begin
              last_d  = size_q + 7'd1;
              state_d = ST_RUN;
            end
            default: begin
              cell_ctrl.clear = 1'b1;
              base_d          = '0;
              state_d         = ST_HOLD;
            end
          endcase
        end
      end
      ST_RUN: begin
        cell_ctrl.shift = 1'b1;
        win1_d = head_row;
        win2_d = win1_q;
        hrow_d = hrow_nx;
        prow_d = hrow_q;
        cnt_d  = cnt_q + 7'd1;
        case (func_q)
          FUNC_TOGGLE: begin
            if (hrow_q == op_row_q) begin
              ins_row   = head_row ^ (ROW_W'(1) << op_col_q);
              res_row_d = ins_row;
            end
          end
          FUNC_READ: begin
            if (hrow_q == op_row_q) begin
              res_row_d = head_row;
            end
          end
          FUNC_STEP: begin
            // first two rows pass through untouched to fill the window
            if (cnt_q >= 7'd2) begin
              ins_row = rule_row;
              if (prow_q == op_row_q) begin
                res_row_d = rule_row;
              end
            end
          end
          default: begin
          end
        endcase
        if (cnt_q == last_q) begin
          state_d = ST_HOLD;
          if (func_q == FUNC_STEP) begin
            base_d = base_nx;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_row_d   = res_row_q;
          out_stat_d  = res_stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      size_d          = sat_size;
      base_d          = '0;
      cell_ctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= CAP_SIZE;
      base_q      <= '0;
      hrow_q      <= '0;
      prow_q      <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      base_q      <= base_d;
      hrow_q      <= hrow_d;
      prow_q      <= prow_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    op_row_q   <= op_row_d;
    op_col_q   <= op_col_d;
    res_row_q  <= res_row_d;
    res_stat_q <= res_stat_d;
    out_row_q  <= out_row_d;
    out_stat_q <= out_stat_d;
    win1_q     <= win1_d;
    win2_q     <= win2_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign row_cells_o = out_row_q;
  assign status_o    = out_stat_q;

  a_shift_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift |-> (state_q == ST_RUN))
    else $error("ring shifted outside an operation");

  a_head_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ({1'b0, hrow_q} < size_q))
    else $error("head row label beyond grid size");

  a_base_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, base_q} < size_q)
    else $error("ring origin beyond grid size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FUNC_CLEAR)) |=> (head_row == '0))
    else $error("clear left live cells");

  a_outside_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((head_row & ~size_mask(size_q)) == '0))
    else $error("live cell outside the grid");

endmodule

### verif/tb_toroidal_life_grid_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toroidal_life_grid_engine
// Self-checking bench for the toroidal B3/S23 life grid. A behavioral copy of
// the grid predicts every row result; directed items cover the grid edges,
// range flags and size saturation, then random phases seed live clusters at
// many grid sizes and evolve them under bursty input and downstream stalls.
// ----------------------------------------------------------------------------
module tb_toroidal_life_grid_engine;
  import tlg_pkg::*;

  localparam int GRID_CAP     = 64;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_LIMIT  = 50000;

  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             status;
  } row_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i      = FUNC_READ;
  logic [IDX_W-1:0]  row_index_i = '0;
  logic [IDX_W-1:0]  col_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ROW_W-1:0]  row_cells_o;
  logic              status_o;

  logic [ROW_W-1:0] life_grid [GRID_CAP];
  int unsigned      grid_size;
  row_result_t      pending_rows [$];
  int               fail_count;
  int               burst_left;
  int               items_sent;

  toroidal_life_grid_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_cells_o (row_cells_o),
    .status_o    (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [ROW_W-1:0] live_mask(int unsigned n);
    if (n >= ROW_W) return '1;
    return (ROW_W'(1) << n) - ROW_W'(1);
  endfunction

  function automatic void clear_life_grid();
    for (int r = 0; r < GRID_CAP; r++) life_grid[r] = '0;
  endfunction

  function automatic void advance_generation();
    logic [ROW_W-1:0] fresh [GRID_CAP];
    int unsigned n, up, dn, lf, rt, cnt;
    n = grid_size;
    for (int r = 0; r < GRID_CAP; r++) fresh[r] = '0;
    for (int unsigned r = 0; r < n; r++) begin
      up = (r + 1 == n) ? 0 : r + 1;
      dn = (r == 0) ? n - 1 : r - 1;
      for (int unsigned c = 0; c < n; c++) begin
        rt = (c + 1 == n) ? 0 : c + 1;
        lf = (c == 0) ? n - 1 : c - 1;
        cnt = 0;
        cnt += life_grid[up][lf];
        cnt += life_grid[up][c];
        cnt += life_grid[up][rt];
        cnt += life_grid[r][lf];
        cnt += life_grid[r][rt];
        cnt += life_grid[dn][lf];
        cnt += life_grid[dn][c];
        cnt += life_grid[dn][rt];
        if (cnt == 3 || (life_grid[r][c] && cnt == 2)) fresh[r][c] = 1'b1;
      end
    end
    for (int r = 0; r < GRID_CAP; r++) life_grid[r] = fresh[r];
  endfunction

  function automatic row_result_t apply_life_op(logic [FUNC_W-1:0] op,
                                                logic [IDX_W-1:0] row,
                                                logic [IDX_W-1:0] col);
    row_result_t res;
    logic        row_ok;
    res.cells  = '0;
    res.status = STATUS_DONE;
    row_ok     = (row < grid_size);
    case (op)
      FUNC_TOGGLE: begin
        if (row_ok && col < grid_size) begin
          life_grid[row][col] = ~life_grid[row][col];
          life_grid[row] &= live_mask(grid_size);
          res.cells = life_grid[row];
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      FUNC_STEP: begin
        advance_generation();
        if (row_ok) res.cells = life_grid[row];
      end
      FUNC_READ: begin
        if (row_ok) res.cells = life_grid[row];
        else res.status = STATUS_RANGE;
      end
      default: begin
        clear_life_grid();
      end
    endcase
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= op;
    row_index_i <= row;
    col_index_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rows.push_back(apply_life_op(op, row, col));
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_grid_size(input logic [SIZE_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (value < MIN_SIZE) grid_size = MIN_SIZE;
    else if (value > GRID_CAP) grid_size = GRID_CAP;
    else grid_size = value;
    clear_life_grid();
  endtask

  task automatic test_reset_grid();
    send_item(FUNC_READ, 6'd63, 6'd0);
    send_item(FUNC_TOGGLE, 6'd0, 6'd0);
    send_item(FUNC_TOGGLE, 6'd63, 6'd63);
    send_item(FUNC_READ, 6'd63, 6'd63);
    send_item(FUNC_TOGGLE, 6'd63, 6'd63);
    send_item(FUNC_STEP, 6'd0, 6'd63);
    send_item(FUNC_CLEAR, 6'd63, 6'd0);
  endtask

  task automatic test_tiny_torus();
    write_grid_size(SIZE_W'(0));
    send_item(FUNC_TOGGLE, 6'd3, 6'd0);
    send_item(FUNC_TOGGLE, 6'd0, 6'd3);
    send_item(FUNC_READ, 6'd3, 6'd0);
    send_item(FUNC_READ, 6'd63, 6'd63);
    send_item(FUNC_TOGGLE, 6'd0, 6'd0);
    send_item(FUNC_TOGGLE, 6'd0, 6'd1);
    send_item(FUNC_TOGGLE, 6'd0, 6'd2);
    send_item(FUNC_STEP, 6'd1, 6'd0);
    send_item(FUNC_STEP, 6'd5, 6'd0);
    send_item(FUNC_CLEAR, 6'd63, 6'd63);
  endtask

  task automatic test_wrap_blinker();
    write_grid_size(SIZE_W'(127));
    send_item(FUNC_TOGGLE, 6'd63, 6'd0);
    send_item(FUNC_TOGGLE, 6'd0, 6'd0);
    send_item(FUNC_TOGGLE, 6'd1, 6'd0);
    send_item(FUNC_STEP, 6'd0, 6'd0);
    send_item(FUNC_STEP, 6'd63, 6'd0);
    send_item(FUNC_READ, 6'd1, 6'd0);
  endtask

  task automatic test_random_life();
    int          start, sel, seeds, gens, span;
    int unsigned n, base_r, base_c;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 11) write_grid_size(SIZE_W'($urandom_range(3, 12)));
      else if (sel < 15) write_grid_size(SIZE_W'($urandom_range(13, 63)));
      else if (sel < 17) write_grid_size(SIZE_W'(64));
      else write_grid_size(SIZE_W'($urandom_range(0, 127)));
      n      = grid_size;
      span   = (n > 10) ? 10 : n;
      base_r = $urandom_range(0, n - 1);
      base_c = $urandom_range(0, n - 1);
      seeds  = $urandom_range(span, span * span / 2 + span);
      // clustered seeding keeps large grids alive for several generations
      repeat (seeds) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(FUNC_READ, pick_index(n), IDX_W'($urandom));
        end else if ($urandom_range(0, 11) == 0) begin
          send_item(FUNC_TOGGLE, pick_index(n), pick_index(n));
        end else begin
          send_item(FUNC_TOGGLE, IDX_W'((base_r + $urandom_range(0, span - 1)) % n),
                    IDX_W'((base_c + $urandom_range(0, span - 1)) % n));
        end
      end
      gens = $urandom_range(4, 20);
      repeat (gens) begin
        send_item(FUNC_STEP, pick_index(n), IDX_W'($urandom));
        repeat ($urandom_range(0, 2)) send_item(FUNC_READ, pick_index(n), IDX_W'($urandom));
        if ($urandom_range(0, 11) == 0) send_item(FUNC_TOGGLE, pick_index(n), pick_index(n));
        if ($urandom_range(0, 29) == 0) begin
          send_item(FUNC_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        end
      end
      if ($urandom_range(0, 5) == 0) send_item(FUNC_CLEAR, pick_index(n), IDX_W'($urandom));
      repeat ($urandom_range(0, 3)) begin
        send_item(FUNC_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  initial begin : downstream_stall
    stall_mode_e mode;
    int          span;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 240);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_ready_i <= 1'b1;
          STALL_HALF:  out_ready_i <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    row_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected item: row_cells=%h status=%b", row_cells_o, status_o);
        end
      end else begin
        want = pending_rows.pop_front();
        if (row_cells_o !== want.cells || status_o !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: row_cells exp %h got %h, status exp %b got %b",
                     want.cells, row_cells_o, want.status, status_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #(64'd6_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run_tests
    int waited;
    fail_count = 0;
    burst_left = 0;
    items_sent = 0;
    grid_size  = GRID_CAP;
    clear_life_grid();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_grid();
    test_tiny_torus();
    test_wrap_blinker();
    test_random_life();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_rows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_rows.size() != 0) begin
      fail_count += pending_rows.size();
      $display("%0d items still expected at end of run", pending_rows.size());
    end
    repeat (70) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
